// ===== hdl/gmbfs_pkg.sv =====
// Shared widths, register codes and types for the grid breadth-first spread block.
`timescale 1ns / 1ps
`default_nettype none

package gmbfs_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam int DIM_W      = 7;
   localparam int STEPS_W    = 16;
   localparam int COUNT_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD_STEPS = 2'd2;

   localparam logic [DIM_W-1:0]   ROWS_RESET  = 7'd64;
   localparam logic [DIM_W-1:0]   COLS_RESET  = 7'd64;
   localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd0;

   // neighbor visiting order
   typedef enum logic [1:0] {
      DIR_DOWN  = 2'd0,
      DIR_UP    = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

endpackage

`default_nettype wire

// ===== hdl/gmbfs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module gmbfs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/grid_multi_source_bfs_spread_core.sv =====
// Top level: seed loading and level-by-level 4-neighbor spread over a grid bitmap.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Beat contents
// req       in         req_valid/stall    func, seed_row, seed_col
// rsp       out        rsp_valid/stall    untouched_count
// csr       in         csr_wr_en          csr_index, csr_wr_data
//
// A seed beat reads the map, then marks the cell; an ignored seed returns to idle.
// A run beat walks each level, pops every frontier cell and checks its in-grid
// neighbors, then wipes every marked cell from the map; the single map RAM
// read-then-write per neighbor sets its length.
// After reset all 2**(row bits + col bits) map entries (4096 by default) are
// cleared with req_stall high; csr writes are taken in every cycle.
// The result waits in an output register; req is taken while it is stalled.

module grid_multi_source_bfs_spread_core #(
   parameter int MAX_ROWS = gmbfs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gmbfs_pkg::DEF_MAX_COLS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_func,
   input  wire logic [gmbfs_pkg::DIM_W-1:0]       req_seed_row,
   input  wire logic [gmbfs_pkg::DIM_W-1:0]       req_seed_col,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [gmbfs_pkg::COUNT_W-1:0]          rsp_untouched_count,
   input  wire logic                              csr_wr_en,
   input  wire logic [gmbfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gmbfs_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int MAP_AW    = ROW_AW + COL_AW;
   localparam int MAP_DEPTH = 1 << MAP_AW;
   localparam int CELLS     = MAX_ROWS * MAX_COLS;
   localparam int QUEUE_AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W     = $clog2(CELLS + 1);
   localparam int DIM_W     = gmbfs_pkg::DIM_W;
   localparam int STEPS_W   = gmbfs_pkg::STEPS_W;
   localparam int COUNT_W   = gmbfs_pkg::COUNT_W;

   typedef enum logic [10:0] {
      S_CLEAR    = 11'b000_0000_0001,
      S_IDLE     = 11'b000_0000_0010,
      S_SEED_CHK = 11'b000_0000_0100,
      S_LEVEL    = 11'b000_0000_1000,
      S_POP      = 11'b000_0001_0000,
      S_CELL     = 11'b000_0010_0000,
      S_NB       = 11'b000_0100_0000,
      S_NB_CHK   = 11'b000_1000_0000,
      S_DONE     = 11'b001_0000_0000,
      S_WIPE_RD  = 11'b010_0000_0000,
      S_WIPE_WR  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [DIM_W-1:0]   grid_rows_ff, grid_rows_in;
   logic [DIM_W-1:0]   grid_cols_ff, grid_cols_in;
   logic [STEPS_W-1:0] spread_steps_ff, spread_steps_in;

   logic [CNT_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   marked_ff, marked_in;
   logic [CNT_W-1:0]   level_rem_ff, level_rem_in;
   logic [CNT_W-1:0]   next_cnt_ff, next_cnt_in;
   logic [STEPS_W-1:0] steps_left_ff, steps_left_in;
   logic [MAP_AW-1:0]  clear_addr_ff, clear_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [ROW_AW-1:0]  pend_r_ff, pend_r_in;
   logic [COL_AW-1:0]  pend_c_ff, pend_c_in;
   logic [ROW_AW-1:0]  cur_r_ff, cur_r_in;
   logic [COL_AW-1:0]  cur_c_ff, cur_c_in;
   gmbfs_pkg::dir_type dir_ff, dir_in;

   logic [DIM_W-1:0]   rows_used;
   logic [DIM_W-1:0]   cols_used;
   logic [2*DIM_W-1:0] cells_used;
   logic [COUNT_W-1:0] untouched;

   logic               req_accept;
   logic               seed_ok;
   logic [ROW_AW-1:0]  seed_r;
   logic [COL_AW-1:0]  seed_c;

   logic               nb_ok;
   logic [ROW_AW-1:0]  nb_r;
   logic [COL_AW-1:0]  nb_c;
   logic               queue_room;
   logic               mark_new;

   logic               map_wr_en;
   logic [MAP_AW-1:0]  map_wr_addr;
   logic               map_wr_data;
   logic [MAP_AW-1:0]  map_rd_addr;
   logic               map_rd_data;

   logic               q_wr_en;
   logic [MAP_AW-1:0]  q_rd_data;

   gmbfs_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // frontier queue holds {row, col}; read always at head
   gmbfs_ram #(
      .WIDTH (MAP_AW),
      .DEPTH (CELLS)
   ) u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (tail_ff[QUEUE_AW-1:0]),
      .wr_data ({pend_r_ff, pend_c_ff}),
      .rd_addr (head_ff[QUEUE_AW-1:0]),
      .rd_data (q_rd_data)
   );

   // grid size saturated to the parameters
   always_comb begin
      rows_used = (32'(grid_rows_ff) > 32'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows_ff;
      cols_used = (32'(grid_cols_ff) > 32'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols_ff;
      cells_used = (2*DIM_W)'(rows_used) * (2*DIM_W)'(cols_used);
      untouched = (32'(cells_used) > 32'(marked_ff))
                  ? COUNT_W'(32'(cells_used) - 32'(marked_ff)) : '0;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      seed_ok = (req_seed_row != '0) && (req_seed_row <= rows_used) &&
                (req_seed_col != '0) && (req_seed_col <= cols_used);
      seed_r  = ROW_AW'(req_seed_row - 7'd1);
      seed_c  = COL_AW'(req_seed_col - 7'd1);
   end

   // shared neighbor step: one direction per visit
   always_comb begin
      nb_r  = cur_r_ff;
      nb_c  = cur_c_ff;
      nb_ok = 1'b0;
      case (dir_ff)
         gmbfs_pkg::DIR_DOWN: begin
            nb_r  = cur_r_ff + ROW_AW'(1);
            nb_ok = (32'(cur_r_ff) + 32'd1 < 32'(rows_used)) &&
                    (32'(cur_c_ff) < 32'(cols_used));
         end
         gmbfs_pkg::DIR_UP: begin
            nb_r  = cur_r_ff - ROW_AW'(1);
            nb_ok = (cur_r_ff != '0) && (32'(cur_r_ff) - 32'd1 < 32'(rows_used)) &&
                    (32'(cur_c_ff) < 32'(cols_used));
         end
         gmbfs_pkg::DIR_RIGHT: begin
            nb_c  = cur_c_ff + COL_AW'(1);
            nb_ok = (32'(cur_c_ff) + 32'd1 < 32'(cols_used)) &&
                    (32'(cur_r_ff) < 32'(rows_used));
         end
         gmbfs_pkg::DIR_LEFT: begin
            nb_c  = cur_c_ff - COL_AW'(1);
            nb_ok = (cur_c_ff != '0) && (32'(cur_c_ff) - 32'd1 < 32'(cols_used)) &&
                    (32'(cur_r_ff) < 32'(rows_used));
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   assign queue_room = (32'(tail_ff) < 32'(CELLS));
   assign mark_new   = !map_rd_data && queue_room;

   always_comb begin
      map_wr_en   = 1'b0;
      map_wr_addr = {pend_r_ff, pend_c_ff};
      map_wr_data = 1'b1;
      map_rd_addr = {nb_r, nb_c};
      q_wr_en     = 1'b0;

      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      marked_in     = marked_ff;
      level_rem_in  = level_rem_ff;
      next_cnt_in   = next_cnt_ff;
      steps_left_in = steps_left_ff;
      clear_addr_in = clear_addr_ff;
      rsp_count_in  = rsp_count_ff;
      pend_r_in     = pend_r_ff;
      pend_c_in     = pend_c_ff;
      cur_r_in      = cur_r_ff;
      cur_c_in      = cur_c_ff;
      dir_in        = dir_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff) inside
         S_CLEAR: begin
            map_wr_en     = 1'b1;
            map_wr_addr   = clear_addr_ff;
            map_wr_data   = 1'b0;
            clear_addr_in = clear_addr_ff + MAP_AW'(1);
            if (clear_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            map_rd_addr = {seed_r, seed_c};
            if (req_accept) begin
               if (req_func) begin
                  steps_left_in = spread_steps_ff;
                  state_in      = S_LEVEL;
               end else if (seed_ok) begin
                  pend_r_in = seed_r;
                  pend_c_in = seed_c;
                  state_in  = S_SEED_CHK;
               end
            end
         end
         S_SEED_CHK: begin
            if (mark_new) begin
               map_wr_en    = 1'b1;
               q_wr_en      = 1'b1;
               tail_in      = tail_ff + CNT_W'(1);
               marked_in    = marked_ff + CNT_W'(1);
               level_rem_in = level_rem_ff + CNT_W'(1);
            end
            state_in = S_IDLE;
         end
         S_LEVEL: begin
            if ((level_rem_ff != '0) && (steps_left_ff != '0)) begin
               next_cnt_in = '0;
               state_in    = S_POP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_POP: begin
            if ((level_rem_ff != '0) && (head_ff < tail_ff)) begin
               state_in = S_CELL;
            end else begin
               // level finished
               level_rem_in  = next_cnt_ff;
               marked_in     = marked_ff + next_cnt_ff;
               next_cnt_in   = '0;
               steps_left_in = steps_left_ff - STEPS_W'(1);
               state_in      = S_LEVEL;
            end
         end
         S_CELL: begin
            cur_r_in = q_rd_data[MAP_AW-1:COL_AW];
            cur_c_in = q_rd_data[COL_AW-1:0];
            dir_in   = gmbfs_pkg::DIR_DOWN;
            state_in = S_NB;
         end
         S_NB, S_NB_CHK: begin
            if (state_ff == S_NB && nb_ok) begin
               pend_r_in = nb_r;
               pend_c_in = nb_c;
               state_in  = S_NB_CHK;
            end else begin
               if (state_ff == S_NB_CHK && mark_new) begin
                  map_wr_en   = 1'b1;
                  q_wr_en     = 1'b1;
                  tail_in     = tail_ff + CNT_W'(1);
                  next_cnt_in = next_cnt_ff + CNT_W'(1);
               end
               if (dir_ff == gmbfs_pkg::DIR_LEFT) begin
                  head_in      = head_ff + CNT_W'(1);
                  level_rem_in = level_rem_ff - CNT_W'(1);
                  state_in     = S_POP;
               end else begin
                  dir_in   = gmbfs_pkg::dir_type'(dir_ff + 2'd1);
                  state_in = S_NB;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = untouched;
               head_in      = '0;
               state_in     = S_WIPE_RD;
            end
         end
         S_WIPE_RD: begin
            // every marked cell sits in the queue: unmark them one by one
            if (head_ff < tail_ff) begin
               state_in = S_WIPE_WR;
            end else begin
               head_in       = '0;
               tail_in       = '0;
               marked_in     = '0;
               level_rem_in  = '0;
               next_cnt_in   = '0;
               steps_left_in = '0;
               state_in      = S_IDLE;
            end
         end
         S_WIPE_WR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = q_rd_data;
            map_wr_data = 1'b0;
            head_in     = head_ff + CNT_W'(1);
            state_in    = S_WIPE_RD;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      grid_rows_in    = grid_rows_ff;
      grid_cols_in    = grid_cols_ff;
      spread_steps_in = spread_steps_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            gmbfs_pkg::CSR_GRID_ROWS:    grid_rows_in    = csr_wr_data[DIM_W-1:0];
            gmbfs_pkg::CSR_GRID_COLS:    grid_cols_in    = csr_wr_data[DIM_W-1:0];
            gmbfs_pkg::CSR_SPREAD_STEPS: spread_steps_in = csr_wr_data[STEPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         grid_rows_ff    <= gmbfs_pkg::ROWS_RESET;
         grid_cols_ff    <= gmbfs_pkg::COLS_RESET;
         spread_steps_ff <= gmbfs_pkg::STEPS_RESET;
         head_ff         <= '0;
         tail_ff         <= '0;
         marked_ff       <= '0;
         level_rem_ff    <= '0;
         next_cnt_ff     <= '0;
         steps_left_ff   <= '0;
         clear_addr_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         dir_ff          <= gmbfs_pkg::DIR_DOWN;
      end else begin
         state_ff        <= state_in;
         grid_rows_ff    <= grid_rows_in;
         grid_cols_ff    <= grid_cols_in;
         spread_steps_ff <= spread_steps_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         marked_ff       <= marked_in;
         level_rem_ff    <= level_rem_in;
         next_cnt_ff     <= next_cnt_in;
         steps_left_ff   <= steps_left_in;
         clear_addr_ff   <= clear_addr_in;
         rsp_valid_ff    <= rsp_valid_in;
         dir_ff          <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      pend_r_ff    <= pend_r_in;
      pend_c_ff    <= pend_c_in;
      cur_r_ff     <= cur_r_in;
      cur_c_ff     <= cur_c_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_untouched_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== hdl/gmbfs_checker.sv =====
// Port-level checker for the grid spread core, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module gmbfs_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              req_func,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [gmbfs_pkg::COUNT_W-1:0]     rsp_untouched_count
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_untouched_count))
      else $error("rsp beat changed while stalled");

   // every accepted run beat leaves the block busy in the following cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func |=> req_stall)
      else $error("req taken right after a run beat");

   // a result only appears while a run is being finished
   a_rsp_during_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall)
      else $error("rsp raised while block idle");

   // map clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall && !rsp_valid)
      else $error("block not clearing after reset");

endmodule

bind grid_multi_source_bfs_spread_core gmbfs_checker u_gmbfs_checker (.*);

`default_nettype wire

// ===== tb/grid_multi_source_bfs_spread_core_test.sv =====
// Self-checking testbench for the grid breadth-first spread core: seed/run stimulus, count checks.
`timescale 1ns / 1ps

class untouched_tracker;
   int unsigned rows_reg;
   int unsigned cols_reg;
   int unsigned steps_reg;
   bit          marked [gmbfs_pkg::DEF_MAX_ROWS * gmbfs_pkg::DEF_MAX_COLS];
   int unsigned frontier [gmbfs_pkg::DEF_MAX_ROWS * gmbfs_pkg::DEF_MAX_COLS];
   int unsigned head, tail, marked_total, level_left, next_count;
   int unsigned last_marked;
   logic [gmbfs_pkg::COUNT_W-1:0] pending_counts [$];
   int unsigned failures;
   int unsigned reported;

   function new();
      rows_reg    = 32'(gmbfs_pkg::ROWS_RESET);
      cols_reg    = 32'(gmbfs_pkg::COLS_RESET);
      steps_reg   = 32'(gmbfs_pkg::STEPS_RESET);
      last_marked = 0;
      failures    = 0;
      reported    = 0;
      wipe();
   endfunction

   function void wipe();
      foreach (marked[i]) marked[i] = 1'b0;
      head         = 0;
      tail         = 0;
      marked_total = 0;
      level_left   = 0;
      next_count   = 0;
   endfunction

   function int unsigned rows_used();
      return rows_reg > gmbfs_pkg::DEF_MAX_ROWS ? gmbfs_pkg::DEF_MAX_ROWS : rows_reg;
   endfunction

   function int unsigned cols_used();
      return cols_reg > gmbfs_pkg::DEF_MAX_COLS ? gmbfs_pkg::DEF_MAX_COLS : cols_reg;
   endfunction

   // 0-based cell; marks and queues it when inside the grid and still clear
   function bit mark_cell(int r, int c);
      int unsigned idx;
      if (r < 0 || c < 0) return 1'b0;
      if (r >= int'(rows_used()) || c >= int'(cols_used())) return 1'b0;
      idx = r * gmbfs_pkg::DEF_MAX_COLS + c;
      if (marked[idx]) return 1'b0;
      if (tail >= gmbfs_pkg::DEF_MAX_ROWS * gmbfs_pkg::DEF_MAX_COLS) return 1'b0;
      marked[idx]    = 1'b1;
      frontier[tail] = idx;
      tail++;
      return 1'b1;
   endfunction

   function void spread_levels();
      int unsigned steps_left;
      int unsigned idx;
      int          r, c;
      steps_left = steps_reg;
      while (level_left > 0 && steps_left > 0) begin
         next_count = 0;
         while (level_left > 0 && head < tail) begin
            idx = frontier[head];
            r   = idx / gmbfs_pkg::DEF_MAX_COLS;
            c   = idx % gmbfs_pkg::DEF_MAX_COLS;
            if (mark_cell(r + 1, c)) next_count++;
            if (mark_cell(r - 1, c)) next_count++;
            if (mark_cell(r, c + 1)) next_count++;
            if (mark_cell(r, c - 1)) next_count++;
            head++;
            level_left--;
         end
         level_left   = next_count;
         marked_total += next_count;
         next_count   = 0;
         steps_left--;
      end
   endfunction

   function void set_reg(logic [gmbfs_pkg::CSR_IDX_W-1:0] idx,
                         logic [gmbfs_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         gmbfs_pkg::CSR_GRID_ROWS:    rows_reg  = 32'(val[gmbfs_pkg::DIM_W-1:0]);
         gmbfs_pkg::CSR_GRID_COLS:    cols_reg  = 32'(val[gmbfs_pkg::DIM_W-1:0]);
         gmbfs_pkg::CSR_SPREAD_STEPS: steps_reg = 32'(val[gmbfs_pkg::STEPS_W-1:0]);
         default: ;
      endcase
   endfunction

   function void take_req(bit is_run, logic [gmbfs_pkg::DIM_W-1:0] row,
                          logic [gmbfs_pkg::DIM_W-1:0] col);
      int unsigned cells;
      if (!is_run) begin
         if (mark_cell(int'(row) - 1, int'(col) - 1)) begin
            marked_total++;
            level_left++;
         end
      end else begin
         spread_levels();
         cells = rows_used() * cols_used();
         pending_counts.push_back(
            gmbfs_pkg::COUNT_W'(cells > marked_total ? cells - marked_total : 0));
         last_marked = marked_total;
         wipe();
      end
   endfunction

   function void check_count(logic [gmbfs_pkg::COUNT_W-1:0] got);
      logic [gmbfs_pkg::COUNT_W-1:0] want;
      if (pending_counts.size() == 0) begin
         failures++;
         if (reported < 10) begin
            $display("untouched count beat with nothing pending: got %0d", got);
            reported++;
         end
         return;
      end
      want = pending_counts.pop_front();
      if (got !== want) begin
         failures++;
         if (reported < 10) begin
            $display("untouched count mismatch: expected %0d, got %0d", want, got);
            reported++;
         end
      end
   endfunction
endclass

module grid_multi_source_bfs_spread_core_test;

   localparam int ITEM_TARGET  = 750;
   localparam int QUIET_TAIL   = 80;
   localparam int LIMIT_CYCLES = 20_000_000;
   localparam int DIM_W        = gmbfs_pkg::DIM_W;
   localparam int COUNT_W      = gmbfs_pkg::COUNT_W;
   localparam int CSR_IDX_W    = gmbfs_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W   = gmbfs_pkg::CSR_DATA_W;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_func = 1'b0;
   logic [DIM_W-1:0]      req_seed_row = '0;
   logic [DIM_W-1:0]      req_seed_col = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COUNT_W-1:0]    rsp_untouched_count;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   untouched_tracker tracker = new();
   int unsigned      cycle_count = 0;
   int unsigned      items_sent = 0;
   int unsigned      stall_left = 0;
   bit               sender_idle_on = 1'b0;
   bit               stall_on = 1'b0;

   always #4 clock = ~clock;

   grid_multi_source_bfs_spread_core DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_seed_row        (req_seed_row),
      .req_seed_col        (req_seed_col),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_untouched_count (rsp_untouched_count),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (reset || !stall_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         stall_left <= $urandom_range(1, 18);
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_count(rsp_untouched_count);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_beat(bit is_run, logic [DIM_W-1:0] row, logic [DIM_W-1:0] col);
      req_valid    <= 1'b1;
      req_func     <= is_run;
      req_seed_row <= row;
      req_seed_col <= col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_req(is_run, row, col);
      if (sender_idle_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (tracker.pending_counts.size() != 0) @(posedge clock);
   endtask

   // registers change only with the block idle; the pause covers the map wipe
   task automatic write_config(int unsigned rows, int unsigned cols, int unsigned steps);
      drain_results();
      repeat (4 * tracker.last_marked + 64) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= gmbfs_pkg::CSR_GRID_ROWS;
      csr_wr_data <= CSR_DATA_W'(rows);
      @(posedge clock);
      tracker.set_reg(gmbfs_pkg::CSR_GRID_ROWS, CSR_DATA_W'(rows));
      csr_index   <= gmbfs_pkg::CSR_GRID_COLS;
      csr_wr_data <= CSR_DATA_W'(cols);
      @(posedge clock);
      tracker.set_reg(gmbfs_pkg::CSR_GRID_COLS, CSR_DATA_W'(cols));
      csr_index   <= gmbfs_pkg::CSR_SPREAD_STEPS;
      csr_wr_data <= CSR_DATA_W'(steps);
      @(posedge clock);
      tracker.set_reg(gmbfs_pkg::CSR_SPREAD_STEPS, CSR_DATA_W'(steps));
      csr_wr_en <= 1'b0;
   endtask

   // mostly small grids; now and then medium, full size, oversize or empty
   function automatic int unsigned pick_dim();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 78) return $urandom_range(1, 12);
      if (sel < 86) return 64;
      if (sel < 92) return $urandom_range(65, 127);
      if (sel < 95) return 0;
      return $urandom_range(13, 63);
   endfunction

   task automatic random_config();
      int unsigned sel, steps;
      sel = $urandom_range(0, 99);
      if (sel < 5) steps = 0;
      else if (sel < 35) steps = $urandom_range(1, 3);
      else if (sel < 75) steps = $urandom_range(4, 30);
      else if (sel < 90) steps = 16'hFFFF;
      else steps = $urandom_range(0, 16'hFFFF);
      write_config(pick_dim(), pick_dim(), steps);
   endtask

   initial begin
      logic [DIM_W-1:0] seed_rows [$];
      logic [DIM_W-1:0] seed_cols [$];
      logic [DIM_W-1:0] row, col;
      int unsigned      n_seeds, sel, pick;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      sender_idle_on = 1'b1;
      stall_on       = 1'b1;

      // full grid, no spread: corners, duplicate, zero and oversize coordinates
      write_config(64, 64, 0);
      send_beat(1'b0, 7'd1, 7'd1);
      send_beat(1'b0, 7'd64, 7'd64);
      send_beat(1'b0, 7'd1, 7'd1);
      send_beat(1'b0, 7'd0, 7'd5);
      send_beat(1'b0, 7'd5, 7'd0);
      send_beat(1'b0, 7'd65, 7'd3);
      send_beat(1'b0, 7'd127, 7'd127);
      send_beat(1'b0, 7'd3, 7'd65);
      send_beat(1'b1, 7'd0, 7'd0);
      send_beat(1'b1, 7'd127, 7'd127);
      // small grid flooded completely
      write_config(3, 4, 16'hFFFF);
      send_beat(1'b0, 7'd2, 7'd2);
      send_beat(1'b1, 7'd0, 7'd0);
      // oversize registers saturate to the full grid, one level
      write_config(100, 127, 1);
      send_beat(1'b0, 7'd64, 7'd64);
      send_beat(1'b0, 7'd100, 7'd1);
      send_beat(1'b1, 7'd0, 7'd0);
      // empty grid
      write_config(0, 5, 3);
      send_beat(1'b0, 7'd1, 7'd1);
      send_beat(1'b1, 7'd0, 7'd0);
      // grid shrinks under loaded seeds; count saturates
      write_config(8, 8, 0);
      send_beat(1'b0, 7'd8, 7'd8);
      send_beat(1'b0, 7'd7, 7'd7);
      send_beat(1'b0, 7'd1, 7'd1);
      write_config(2, 2, 2);
      send_beat(1'b1, 7'd0, 7'd0);
      // partial spread
      write_config(10, 10, 3);
      send_beat(1'b0, 7'd5, 7'd5);
      send_beat(1'b1, 7'd0, 7'd0);

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
            sender_idle_on = 1'b0;
            stall_on       = 1'b0;
         end else begin
            sender_idle_on = ($urandom_range(0, 3) != 0);
            stall_on       = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 2) == 0) random_config();
         else if ($urandom_range(0, 7) == 0) drain_results();

         seed_rows.delete();
         seed_cols.delete();
         n_seeds = $urandom_range(0, 6);
         for (int k = 0; k < n_seeds; k++) begin
            // size change while seeds are loaded
            if (k > 0 && $urandom_range(0, 19) == 0) random_config();
            sel = $urandom_range(0, 99);
            if (sel < 8 && seed_rows.size() > 0) begin
               pick = $urandom_range(0, seed_rows.size() - 1);
               row  = seed_rows[pick];
               col  = seed_cols[pick];
            end else if (sel < 16 || tracker.rows_used() == 0 || tracker.cols_used() == 0) begin
               row = DIM_W'($urandom_range(0, 127));
               col = DIM_W'($urandom_range(0, 127));
            end else begin
               row = DIM_W'($urandom_range(1, tracker.rows_used()));
               col = DIM_W'($urandom_range(1, tracker.cols_used()));
            end
            seed_rows.push_back(row);
            seed_cols.push_back(col);
            items_sent++;
            send_beat(1'b0, row, col);
         end
         send_beat(1'b1, DIM_W'($urandom_range(0, 127)), DIM_W'($urandom_range(0, 127)));
         items_sent++;
      end

      drain_results();
      repeat (200) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_counts.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
